@@ sv/obb_pkg.sv @@
// Shared constants and types for the oriented box overlap test.
package obb_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FIELD_W         = 48;
   localparam int NUM_FIELDS      = 10;
   localparam int AXIS_W          = 16;
   localparam int ONE_Q14         = 16384;
   localparam int LW              = 2 * AXIS_W + 1;
   localparam int THR_W           = 16;
   localparam int FACE_LIM_SHIFT  = 12;
   localparam int CROSS_LIM_SHIFT = 40;
   localparam int NUM_AXES        = 15;
   localparam int NUM_FACE_AXES   = 6;
   localparam int REQ_DATA_W      = NUM_FIELDS * FIELD_W;
   localparam int RSP_DATA_W      = 8;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef logic signed [AXIS_W-1:0] axis_comp_type;
   typedef axis_comp_type [2:0]      axis_vec_type;
   typedef axis_vec_type [2:0]       axis_set_type;

   typedef logic signed [LW-1:0]     lcomp_type;
   typedef lcomp_type [2:0]          lvec_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

@@ sv/obb_front.sv @@
// Front stage: unpacks the boxes, forms offsets and half sizes, and builds the 15 axes.
module obb_front #(
   parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic                                kind,
   input  logic [obb_pkg::REQ_DATA_W-1:0]      fields,
   output obb_pkg::lvec_type                   axes [obb_pkg::NUM_AXES],
   output logic [3*(COORD_WIDTH+2)-1:0]        d_ff,
   output obb_pkg::axis_set_type               a_ax_ff,
   output obb_pkg::axis_set_type               b_ax_ff,
   output logic [3*(COORD_WIDTH+1)-1:0]        ahm_ff,
   output logic [3*(COORD_WIDTH+1)-1:0]        bhm_ff
);

   localparam int CW = COORD_WIDTH;
   localparam int HW = CW + 1;
   localparam int DW = CW + 2;
   localparam int FW = obb_pkg::FIELD_W;
   localparam int AW = obb_pkg::AXIS_W;
   localparam int LW = obb_pkg::LW;

   obb_pkg::lvec_type     l_in [obb_pkg::NUM_AXES];
   obb_pkg::lvec_type     l_ff [obb_pkg::NUM_AXES];
   obb_pkg::axis_set_type a_in;
   obb_pkg::axis_set_type b_in;
   logic [3*DW-1:0]       d_in;
   logic [3*HW-1:0]       ahm_in;
   logic [3*HW-1:0]       bhm_in;

   // Component i of a coordinate field; bits beyond the field read as zero.
   function automatic logic signed [CW-1:0] coord(input logic [FW-1:0] w, input int i);
      logic [3*CW-1:0] e;
      e = (3*CW)'(w);
      return $signed(e[i*CW +: CW]);
   endfunction

   function automatic logic [HW-1:0] mag_h(input logic signed [HW-1:0] x);
      return x[HW-1] ? $unsigned(-x) : $unsigned(x);
   endfunction

   always_comb begin
      logic signed [CW-1:0] pa, qa, pb, qb;
      logic signed [HW-1:0] ac, ah, bh;
      logic signed [DW-1:0] dd;
      logic [FW-1:0]        fa_c, fa_h, fb_c, fb_h;
      fa_c = fields[0*FW +: FW];
      fa_h = fields[1*FW +: FW];
      fb_c = fields[5*FW +: FW];
      fb_h = fields[6*FW +: FW];
      for (int i = 0; i < 3; i++) begin
         pa = coord(fa_c, i);
         qa = coord(fa_h, i);
         pb = coord(fb_c, i);
         qb = coord(fb_h, i);
         if (kind) begin
            ac = HW'(pa) + HW'(qa);
            ah = HW'(qa) - HW'(pa);
         end else begin
            ac = HW'(pa) + HW'(pa);
            ah = HW'(qa) + HW'(qa);
         end
         bh = HW'(qb) + HW'(qb);
         dd = DW'(pb) + DW'(pb) - DW'(ac);
         d_in[i*DW +: DW]   = dd;
         ahm_in[i*HW +: HW] = mag_h(ah);
         bhm_in[i*HW +: HW] = mag_h(bh);
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (kind) begin
               a_in[k][i] = (k == i) ? AW'(obb_pkg::ONE_Q14) : '0;
            end else begin
               a_in[k][i] = $signed(fields[(2+k)*FW + i*AW +: AW]);
            end
            b_in[k][i] = $signed(fields[(7+k)*FW + i*AW +: AW]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            l_in[k][i]   = LW'(a_in[k][i]);
            l_in[3+k][i] = LW'(b_in[k][i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            l_in[6+3*i+j][0] = LW'(a_in[i][1]) * LW'(b_in[j][2])
                             - LW'(a_in[i][2]) * LW'(b_in[j][1]);
            l_in[6+3*i+j][1] = LW'(a_in[i][2]) * LW'(b_in[j][0])
                             - LW'(a_in[i][0]) * LW'(b_in[j][2]);
            l_in[6+3*i+j][2] = LW'(a_in[i][0]) * LW'(b_in[j][1])
                             - LW'(a_in[i][1]) * LW'(b_in[j][0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff    <= l_in;
         d_ff    <= d_in;
         a_ax_ff <= a_in;
         b_ax_ff <= b_in;
         ahm_ff  <= ahm_in;
         bhm_ff  <= bhm_in;
      end
   end

   assign axes = l_ff;

endmodule

@@ sv/obb_axis_test.sv @@
// Projection and comparison pipeline for one candidate separating axis.
module obb_axis_test #(
   parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF,
   parameter bit IS_CROSS    = 1'b0
) (
   input  logic                           clock,
   input  obb_pkg::stage_en_type          en,
   input  obb_pkg::lvec_type              l,
   input  logic [3*(COORD_WIDTH+2)-1:0]   d,
   input  obb_pkg::axis_set_type          a_ax,
   input  obb_pkg::axis_set_type          b_ax,
   input  logic [3*(COORD_WIDTH+1)-1:0]   ahm,
   input  logic [3*(COORD_WIDTH+1)-1:0]   bhm,
   input  logic [obb_pkg::THR_W-1:0]      thr,
   output logic                           sep
);

   localparam int LW   = obb_pkg::LW;
   localparam int HW   = COORD_WIDTH + 1;
   localparam int DW   = COORD_WIDTH + 2;
   localparam int PDW  = LW + DW;
   localparam int SDW  = PDW + 2;
   localparam int PAW  = LW + obb_pkg::AXIS_W;
   localparam int SAW  = PAW + 2;
   localparam int SQW  = 2 * LW;
   localparam int LSW  = SQW + 2;
   localparam int RTW  = SAW + HW;
   localparam int RSW  = RTW + 3;
   localparam int LHW  = SDW + 14;
   localparam int CMPW = (RSW > LHW) ? RSW : LHW;
   localparam int LIM_SHIFT = IS_CROSS ? obb_pkg::CROSS_LIM_SHIFT : obb_pkg::FACE_LIM_SHIFT;

   // Stage 2: component products.
   logic signed [PDW-1:0] pd_ff [3];
   logic signed [PAW-1:0] pa_ff [3][3];
   logic signed [PAW-1:0] pb_ff [3][3];
   logic signed [SQW-1:0] sq_ff [3];
   // Stage 3: projection magnitudes.
   logic [SDW-1:0]        c_ff;
   logic [SAW-1:0]        ma_ff [3];
   logic [SAW-1:0]        mb_ff [3];
   logic                  skip3_ff;
   // Stage 4: radius terms.
   logic [RTW-1:0]        ra_ff [3];
   logic [RTW-1:0]        rb_ff [3];
   logic [LHW-1:0]        lhs_ff;
   logic                  skip4_ff;
   // Stage 5: verdict.
   logic                  sep_ff;

   logic [SDW-1:0] c_in;
   logic [SAW-1:0] ma_in [3];
   logic [SAW-1:0] mb_in [3];
   logic           skip_in;
   logic [RSW-1:0] rsum_in;
   logic           sep_in;

   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int i = 0; i < 3; i++) begin
            pd_ff[i] <= l[i] * $signed(d[i*DW +: DW]);
            sq_ff[i] <= l[i] * l[i];
            for (int k = 0; k < 3; k++) begin
               pa_ff[k][i] <= l[i] * a_ax[k][i];
               pb_ff[k][i] <= l[i] * b_ax[k][i];
            end
         end
      end
   end

   always_comb begin
      logic signed [SDW-1:0] sd;
      logic signed [SAW-1:0] sa, sb;
      logic [LSW-1:0]        lsq, lim;
      sd = SDW'(pd_ff[0]) + SDW'(pd_ff[1]) + SDW'(pd_ff[2]);
      c_in = sd[SDW-1] ? $unsigned(-sd) : $unsigned(sd);
      for (int k = 0; k < 3; k++) begin
         sa = SAW'(pa_ff[k][0]) + SAW'(pa_ff[k][1]) + SAW'(pa_ff[k][2]);
         sb = SAW'(pb_ff[k][0]) + SAW'(pb_ff[k][1]) + SAW'(pb_ff[k][2]);
         ma_in[k] = sa[SAW-1] ? $unsigned(-sa) : $unsigned(sa);
         mb_in[k] = sb[SAW-1] ? $unsigned(-sb) : $unsigned(sb);
      end
      // Squares are never negative, so the sum is read as unsigned.
      lsq = LSW'($unsigned(sq_ff[0])) + LSW'($unsigned(sq_ff[1]))
          + LSW'($unsigned(sq_ff[2]));
      lim = LSW'(thr) << LIM_SHIFT;
      skip_in = lsq < lim;
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         c_ff     <= c_in;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         skip3_ff <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         for (int k = 0; k < 3; k++) begin
            ra_ff[k] <= RTW'(ma_ff[k]) * RTW'(ahm[k*HW +: HW]);
            rb_ff[k] <= RTW'(mb_ff[k]) * RTW'(bhm[k*HW +: HW]);
         end
         lhs_ff   <= LHW'(c_ff) << 14;
         skip4_ff <= skip3_ff;
      end
   end

   always_comb begin
      rsum_in = RSW'(ra_ff[0]) + RSW'(ra_ff[1]) + RSW'(ra_ff[2])
              + RSW'(rb_ff[0]) + RSW'(rb_ff[1]) + RSW'(rb_ff[2]);
      sep_in  = !skip4_ff && (CMPW'(lhs_ff) > CMPW'(rsum_in));
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         sep_ff <= sep_in;
      end
   end

   assign sep = sep_ff;

endmodule

@@ sv/obb_obb_overlap_test_top.sv @@
// Top level of the oriented box overlap test: stream ports, stage control and verdict.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_tvalid/req_tready  req_tdata (ten box fields), req_tuser (kind)
//   rsp       out        rsp_tvalid/rsp_tready  rsp_tdata (overlap)
//   csr       in         csr_wr_en              csr_wr_data (axis zero threshold)
//
// The block takes one box pair per cycle while rsp is not stalled, and presents its verdict
// word on rsp once the pair's accepted word has passed through every register stage.
// The depth is set by the multiplier chain: cross axes, then component products, then the
// radius products, each followed by a register stage.
// Reset clears every stage valid bit and sets the threshold to one; payload is not reset.
// Each stage holds its word while the one after it is full and stalled, so gaps in the
// pipeline close up under back-pressure and no word is lost or repeated.
module obb_obb_overlap_test_top #(
   parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: a_center_or_min, a_half_or_max, a_axis_x, a_axis_y, a_axis_z,
   // b_center, b_half_size, b_axis_x, b_axis_y, b_axis_z (48 bits each).
   input  logic [obb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Bit 0: kind.
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Bit 0: overlap; upper bits are zero.
   output logic [obb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [obb_pkg::THR_W-1:0]         csr_wr_data
);

   localparam int HW = COORD_WIDTH + 1;
   localparam int NS = 7;

   logic [obb_pkg::THR_W-1:0]      thr_ff;
   logic [NS-1:0]                  v_ff;
   logic [NS-1:0]                  v_in;
   logic [NS-1:0]                  en;
   logic                           kind0_ff;
   logic [obb_pkg::REQ_DATA_W-1:0] data0_ff;
   logic [3*HW-1:0]                ahm1, bhm1;
   logic [3*HW-1:0]                ahm2_ff, bhm2_ff, ahm3_ff, bhm3_ff;
   logic [3*(COORD_WIDTH+2)-1:0]   d1;
   obb_pkg::axis_set_type          a_ax1, b_ax1;
   obb_pkg::lvec_type              axes1 [obb_pkg::NUM_AXES];
   obb_pkg::stage_en_type          st_en;
   logic [obb_pkg::NUM_AXES-1:0]   sep;
   logic                           overlap_ff;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         thr_ff <= obb_pkg::THR_RESET;
      end else begin
         v_ff <= v_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Stage 0 captures the accepted word.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         kind0_ff <= req_tuser;
         data0_ff <= req_tdata;
      end
   end

   // Stage 1: unpacking, offsets and the fifteen axes.
   obb_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock   (clock),
      .en      (en[1]),
      .kind    (kind0_ff),
      .fields  (data0_ff),
      .axes    (axes1),
      .d_ff    (d1),
      .a_ax_ff (a_ax1),
      .b_ax_ff (b_ax1),
      .ahm_ff  (ahm1),
      .bhm_ff  (bhm1)
   );

   // Half sizes travel alongside until the radius products in stage 4 need them.
   always_ff @(posedge clock) begin
      if (en[2]) begin
         ahm2_ff <= ahm1;
         bhm2_ff <= bhm1;
      end
      if (en[3]) begin
         ahm3_ff <= ahm2_ff;
         bhm3_ff <= bhm2_ff;
      end
   end

   assign st_en = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};

   // Stages 2 to 5: one projection pipeline per candidate axis; the first six are face axes.
   for (genvar g = 0; g < obb_pkg::NUM_AXES; g++) begin : g_axis
      obb_axis_test #(
         .COORD_WIDTH (COORD_WIDTH),
         .IS_CROSS    (g >= obb_pkg::NUM_FACE_AXES)
      ) u_axis (
         .clock (clock),
         .en    (st_en),
         .l     (axes1[g]),
         .d     (d1),
         .a_ax  (a_ax1),
         .b_ax  (b_ax1),
         .ahm   (ahm3_ff),
         .bhm   (bhm3_ff),
         .thr   (thr_ff),
         .sep   (sep[g])
      );
   end

   // Stage 6: the boxes overlap when no axis separates them.
   always_ff @(posedge clock) begin
      if (en[6]) begin
         overlap_ff <= ~|sep;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = {(obb_pkg::RSP_DATA_W-1)'(0), overlap_ff};

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the oriented box overlap test block.
module tb_top;

   typedef longint      vec3_type[3];
   typedef vec3_type    mat3_type[3];

   // One row of the directed stimulus table. When known is set, the verdict is typed in.
   typedef struct {
      bit                             kind;
      logic [obb_pkg::REQ_DATA_W-1:0] fields;
      bit                             known;
      bit                             verdict;
   } box_pair_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_PAIRS   = 1100;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // From bit 0: the ten 48-bit box fields, box A first.
   logic [obb_pkg::REQ_DATA_W-1:0]   req_tdata;
   // Bit 0: kind.
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // Bit 0: overlap; upper bits zero.
   logic [obb_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_wr_en;
   logic [obb_pkg::THR_W-1:0]        csr_wr_data;

   // Our own copy of the axis zero threshold, kept in step with every register write.
   logic [obb_pkg::THR_W-1:0]        threshold_q;
   // Expected verdict bytes, oldest first.
   logic [obb_pkg::RSP_DATA_W-1:0]   verdicts_due[$];
   box_pair_type                     directed_rows[$];
   int                               fail_count;
   int                               idle_cycles;

   obb_obb_overlap_test_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [obb_pkg::FIELD_W-1:0] pack3(int c0, int c1, int c2);
      return {c2[15:0], c1[15:0], c0[15:0]};
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return (x < 0) ? longint'(-x) : x;
   endfunction

   function automatic longint dot3(vec3_type p, vec3_type q);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   function automatic vec3_type unpack3(logic [obb_pkg::FIELD_W-1:0] f);
      vec3_type v;
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'($signed(f[16*i +: 16]));
      end
      return v;
   endfunction

   // True when the candidate axis separates the two projections. The squared length of
   // any axis always fits in 64 bits.
   function automatic bit axis_separates(vec3_type ax, longint unsigned lim, vec3_type d,
                                         mat3_type aa, vec3_type ah, mat3_type ba,
                                         vec3_type bh);
      longint unsigned lsq;
      logic [127:0]    gap;
      logic [127:0]    reach;
      lsq = 0;
      for (int k = 0; k < 3; k++) begin
         lsq += magnitude(ax[k]) * magnitude(ax[k]);
      end
      if (lsq < lim) begin
         return 1'b0;
      end
      gap   = 128'(magnitude(dot3(ax, d))) << 14;
      reach = '0;
      for (int k = 0; k < 3; k++) begin
         reach += 128'(magnitude(dot3(ax, aa[k]))) * 128'(magnitude(ah[k]));
         reach += 128'(magnitude(dot3(ax, ba[k]))) * 128'(magnitude(bh[k]));
      end
      return gap > reach;
   endfunction

   function automatic bit predict_overlap(bit kind, logic [obb_pkg::REQ_DATA_W-1:0] f);
      vec3_type p, q, ac, ah, bc, bh, d, cross_ax;
      mat3_type aa, ba;
      longint unsigned face_lim, cross_lim;
      bit sep;
      p = unpack3(f[0*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      q = unpack3(f[1*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      for (int i = 0; i < 3; i++) begin
         if (kind) begin
            ac[i] = p[i] + q[i];
            ah[i] = q[i] - p[i];
            for (int j = 0; j < 3; j++) begin
               aa[i][j] = (i == j) ? obb_pkg::ONE_Q14 : 0;
            end
         end else begin
            ac[i] = 2 * p[i];
            ah[i] = 2 * q[i];
            aa[i] = unpack3(f[(2+i)*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
         end
      end
      p = unpack3(f[5*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      q = unpack3(f[6*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      for (int i = 0; i < 3; i++) begin
         bc[i] = 2 * p[i];
         bh[i] = 2 * q[i];
         d[i]  = bc[i] - ac[i];
         ba[i] = unpack3(f[(7+i)*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      end
      face_lim  = longint'(threshold_q) << obb_pkg::FACE_LIM_SHIFT;
      cross_lim = longint'(threshold_q) << obb_pkg::CROSS_LIM_SHIFT;
      sep = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sep |= axis_separates(aa[i], face_lim, d, aa, ah, ba, bh);
         sep |= axis_separates(ba[i], face_lim, d, aa, ah, ba, bh);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cross_ax[0] = aa[i][1] * ba[j][2] - aa[i][2] * ba[j][1];
            cross_ax[1] = aa[i][2] * ba[j][0] - aa[i][0] * ba[j][2];
            cross_ax[2] = aa[i][0] * ba[j][1] - aa[i][1] * ba[j][0];
            sep |= axis_separates(cross_ax, cross_lim, d, aa, ah, ba, bh);
         end
      end
      return !sep;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Packs a pair from its ten fields, box A first.
   function automatic logic [obb_pkg::REQ_DATA_W-1:0] pack_pair(
         logic [obb_pkg::FIELD_W-1:0] a_c, logic [obb_pkg::FIELD_W-1:0] a_h,
         logic [obb_pkg::FIELD_W-1:0] b_c, logic [obb_pkg::FIELD_W-1:0] b_h,
         logic [3*obb_pkg::FIELD_W-1:0] a_ax, logic [3*obb_pkg::FIELD_W-1:0] b_ax);
      return {b_ax, b_h, b_c, a_ax, a_h, a_c};
   endfunction

   function automatic logic [obb_pkg::FIELD_W-1:0] any_field();
      return obb_pkg::FIELD_W'({$urandom(), $urandom()});
   endfunction

   // A set of three axes: mostly a rotation about one world axis, sometimes loose values.
   function automatic logic [3*obb_pkg::FIELD_W-1:0] random_axes();
      int m[3][3];
      int cosines[4] = '{16384, 14189, 11585, 8192};
      int sines[4]   = '{0, 8192, 11585, 14189};
      int sel, k, a, b, s;
      logic [3*obb_pkg::FIELD_W-1:0] r;
      sel = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m[i][j] = (i == j) ? obb_pkg::ONE_Q14 : 0;
         end
      end
      if (sel == 0) begin
         return {any_field(), any_field(), any_field()};
      end else if (sel < 3) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               m[i][j] = int'($urandom_range(0, 32768)) - 16384;
            end
         end
      end else begin
         k = $urandom_range(0, 2);
         a = (k + 1) % 3;
         b = (k + 2) % 3;
         s = $urandom_range(0, 3);
         m[a][a] = cosines[s];
         m[b][b] = cosines[s];
         m[a][b] = $urandom_range(0, 1) ? sines[s] : -sines[s];
         m[b][a] = -m[a][b];
      end
      for (int i = 0; i < 3; i++) begin
         r[i*obb_pkg::FIELD_W +: obb_pkg::FIELD_W] = pack3(m[i][0], m[i][1], m[i][2]);
      end
      return r;
   endfunction

   function automatic logic [obb_pkg::FIELD_W-1:0] random_spot();
      if ($urandom_range(0, 19) == 0) begin
         return any_field();
      end
      return pack3(int'($urandom_range(0, 2048)) - 1024, int'($urandom_range(0, 2048)) - 1024,
                   int'($urandom_range(0, 2048)) - 1024);
   endfunction

   function automatic logic [obb_pkg::FIELD_W-1:0] random_half();
      if ($urandom_range(0, 19) == 0) begin
         return any_field();
      end
      return pack3($urandom_range(0, 512), $urandom_range(0, 512), $urandom_range(0, 512));
   endfunction

   function automatic box_pair_type random_pair();
      box_pair_type r;
      logic [obb_pkg::FIELD_W-1:0] lo, hi;
      r.kind    = ($urandom_range(0, 2) == 0);
      r.known   = 1'b0;
      r.verdict = 1'b0;
      lo = random_spot();
      hi = random_half();
      if (r.kind && $urandom_range(0, 3) != 0) begin
         // Axis-aligned box A: max corner is min plus a span, mostly in the right order.
         for (int i = 0; i < 3; i++) begin
            hi[16*i +: 16] = lo[16*i +: 16] + 16'(2 * hi[16*i +: 16]);
         end
      end
      r.fields = pack_pair(lo, hi, random_spot(), random_half(), random_axes(),
                           random_axes());
      return r;
   endfunction

   // ---------------------------------------------------------------- driving tasks

   // Offers one word and waits for it to be taken; the expectation is queued on acceptance.
   task automatic send_pair(box_pair_type row);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = row.fields;
      req_tuser  = row.kind;
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (row.known) begin
         verdicts_due = {verdicts_due, obb_pkg::RSP_DATA_W'(row.verdict)};
      end else begin
         verdicts_due = {verdicts_due,
                         obb_pkg::RSP_DATA_W'(predict_overlap(row.kind, row.fields))};
      end
   endtask

   task automatic sender_gap(int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Drains the pipeline and lets it settle before touching the register.
   task automatic wait_drained();
      sender_gap(0);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [obb_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      threshold_q = value;
   endtask

   task automatic add_row(bit kind, logic [obb_pkg::REQ_DATA_W-1:0] f, bit known,
                          bit verdict);
      box_pair_type r;
      r.kind    = kind;
      r.fields  = f;
      r.known   = known;
      r.verdict = verdict;
      directed_rows = {directed_rows, r};
   endtask

   // Sends a batch of random pairs in bursts of random length with random gaps.
   task automatic send_random(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++, count--) begin
            send_pair(random_pair());
         end
         if ($urandom_range(0, 2) != 0) begin
            sender_gap($urandom_range(0, 10));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver and checker

   // The receiver picks a new stall habit at regular points of its cycle count: always ready,
   // coin toss, or ready on a sparse regular pattern.
   int stall_mode;
   int rx_cycle;
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) begin
         stall_mode <= $urandom_range(0, 2);
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_tready <= (rx_cycle % 4 == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== verdicts_due[0]) begin
               $display("%0t: overlap mismatch, expected %h, actual %h", $time,
                        verdicts_due[0], rsp_tdata);
               fail_count++;
            end
            void'(verdicts_due.pop_front());
         end
      end
   end

   // The watchdog counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      logic [obb_pkg::FIELD_W-1:0]   zero3, one3, neg_one3;
      logic [3*obb_pkg::FIELD_W-1:0] world_axes;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      threshold_q = obb_pkg::THR_RESET;
      fail_count  = 0;
      idle_cycles = 0;
      stall_mode  = 0;
      rx_cycle    = 0;
      zero3      = '0;
      one3       = pack3(256, 256, 256);
      neg_one3   = pack3(-256, -256, -256);
      world_axes = {pack3(0, 0, obb_pkg::ONE_Q14), pack3(0, obb_pkg::ONE_Q14, 0),
                    pack3(obb_pkg::ONE_Q14, 0, 0)};

      // Directed table. Unit boxes on world axes: centred together, apart, and touching.
      add_row(1'b0, pack_pair(zero3, one3, zero3, one3, world_axes, world_axes), 1, 1'b1);
      add_row(1'b0, pack_pair(zero3, one3, pack3(768, 0, 0), one3, world_axes, world_axes),
              1, 1'b0);
      add_row(1'b0, pack_pair(zero3, one3, pack3(512, 0, 0), one3, world_axes, world_axes),
              1, 1'b1);
      // Axis-aligned box A given by corners, touching B, then with min above max.
      add_row(1'b1, pack_pair(neg_one3, one3, pack3(512, 0, 0), one3, '0, world_axes),
              1, 1'b1);
      add_row(1'b1, pack_pair(one3, neg_one3, pack3(768, 0, 0), one3, '1, world_axes),
              1, 1'b0);
      // Negative half sizes count by magnitude.
      add_row(1'b0, pack_pair(zero3, neg_one3, pack3(0, 768, 0), neg_one3, world_axes,
              world_axes), 1, 1'b0);
      // Every axis zero: nothing can separate, however far apart.
      add_row(1'b0, pack_pair(zero3, one3, pack3(2000, 0, 0), one3, '0, '0), 1, 1'b1);
      add_row(1'b0, '0, 1, 1'b1);
      // Field extremes, checked by prediction.
      add_row(1'b0, '1, 0, 1'b0);
      add_row(1'b1, '1, 0, 1'b0);
      add_row(1'b0, {30{16'h7FFF}}, 0, 1'b0);
      add_row(1'b0, {30{16'h8000}}, 0, 1'b0);
      add_row(1'b1, {30{16'h8000}}, 0, 1'b0);
      add_row(1'b0, {15{32'h8000_7FFF}}, 0, 1'b0);
      // Non-unit and parallel axes, and far boxes along a diagonal.
      add_row(1'b0, pack_pair(zero3, one3, pack3(300, 300, 300), one3,
              {3{pack3(obb_pkg::ONE_Q14, obb_pkg::ONE_Q14, 0)}},
              {3{pack3(-obb_pkg::ONE_Q14, -obb_pkg::ONE_Q14, 0)}}), 0, 1'b0);
      add_row(1'b0, pack_pair(pack3(-32768, 32767, 0), pack3(32767, 0, 32767),
              pack3(32767, -32768, 0), pack3(-32768, 32767, 0), world_axes, world_axes),
              0, 1'b0);
      for (int i = 0; i < 6; i++) begin
         directed_rows = {directed_rows, random_pair()};
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows run at the reset threshold of one.
      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i]);
      end

      // Random phases, each under its own threshold; the sender waits out every result
      // before each register write.
      wait_drained();
      write_threshold('0);
      send_random(RANDOM_PAIRS / 4);
      wait_drained();
      write_threshold('1);
      send_random(RANDOM_PAIRS / 4);
      wait_drained();
      write_threshold(obb_pkg::THR_W'($urandom_range(2, 65534)));
      send_random(RANDOM_PAIRS / 4);
      wait_drained();
      write_threshold(obb_pkg::THR_RESET);
      send_random(RANDOM_PAIRS / 4);
      wait_drained();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/obb_pkg.sv
sv/obb_front.sv
sv/obb_axis_test.sv
sv/obb_obb_overlap_test_top.sv
verif/tb_top.sv
